// ===== rtl/core/triggered_scope_capture_assert.svh =====
// assertion macros used by the port-level checker file of the capture engine
// no dependencies; take in with `include before use
`ifndef TRIGGERED_SCOPE_CAPTURE_ASSERT_SVH
`define TRIGGERED_SCOPE_CAPTURE_ASSERT_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define TSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/tsc_pkg.sv =====
// types and constants of the triggered capture engine
// no dependencies; used by the top level, the checker and the testbench
package tsc_pkg;

   localparam int DEPTH    = 512;
   localparam int SAMPLE_W = 16;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int CTR_W    = 17;
   localparam int CSR_W    = 16;
   localparam logic [CTR_W-1:0] CTR_MAX = '1;

   typedef enum logic [2:0] {
      CSR_DECIMATION       = 3'd0,
      CSR_EXTERNAL_TRIGGER = 3'd1,
      CSR_TRIGGER_LEVEL    = 3'd2,
      CSR_HYSTERESIS       = 3'd3,
      CSR_HOLD_LIMIT       = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      SCH_UNKNOWN = 3'b001,
      SCH_LOW     = 3'b010,
      SCH_HIGH    = 3'b100
   } schmitt_type;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] x_sample;
      logic                       x_active;
      logic signed [SAMPLE_W-1:0] trig_sample;
      logic                       trig_active;
      logic [ADDR_W-1:0]          read_address;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] read_data;
      logic [COUNT_W-1:0]         stored_count;
      logic                       waiting_trigger;
      logic                       restarted;
      logic                       channel_active;
   } rsp_type;

endpackage

// ===== rtl/core/tsc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/triggered_scope_capture.sv =====
// top level of the triggered capture engine: decimated sample store with
// schmitt re-arm and hold timeout; depends on tsc_pkg and tsc_ram
//
//   channel  ports                          moves
//   req      req_valid/req_ready/req_data   sample step or store read
//   rsp      rsp_valid/rsp_ready/rsp_data   one result per request
//   csr      csr_we/csr_index/csr_wdata     register write, no wait
//
// one transaction per cycle sustained while rsp is not stalled; a result is registered
// first with the registered read of the sample ram, then in the output register.
// control state updates at the accepting edge, so a read right after a write sees it.
// reset needs no clearing pass: a high-water count marks which entries were ever
// written and all others read as zero. a stalled rsp holds the pipe and drops req_ready.
module triggered_scope_capture
   import tsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef struct packed {
      logic               is_read;
      logic               hit;
      logic [COUNT_W-1:0] stored_count;
      logic               waiting_trigger;
      logic               restarted;
      logic               channel_active;
   } stage_type;

   // configuration
   logic [15:0]        decimation_ff;
   logic               external_ff;
   logic signed [15:0] level_ff;
   logic [14:0]        hyst_ff;
   logic [15:0]        hold_ff;

   // control state
   logic [CW-1:0]    wp_ff, wp_in;
   logic [CW-1:0]    hw_ff, hw_in;
   logic             full_ff, full_in;
   logic [CTR_W-1:0] fc_ff, fc_in;
   schmitt_type      sch_ff, sch_in;
   logic             active_ff, active_in;

   // pipeline
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff, out_in;

   logic accept;
   logic advance;
   logic restart;
   logic wr_en;
   logic rd_en;
   logic [SAMPLE_W-1:0] rd_data;

   logic signed [17:0] gate;
   logic signed [17:0] hi_th;
   logic signed [17:0] lo_th;
   logic [CTR_W-1:0]   fc_a;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign rd_en     = accept && (req_data.op == OP_READ);

   assign hi_th = 18'(level_ff);
   assign lo_th = 18'(level_ff) - 18'($signed({1'b0, hyst_ff}));
   assign gate  = external_ff ? 18'(req_data.trig_sample) : 18'(req_data.x_sample);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff <= 16'd3;
         external_ff   <= 1'b0;
         level_ff      <= '0;
         hyst_ff       <= 15'd328;
         hold_ff       <= 16'd4410;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DECIMATION:       decimation_ff <= csr_wdata;
            CSR_EXTERNAL_TRIGGER: external_ff   <= csr_wdata[0];
            CSR_TRIGGER_LEVEL:    level_ff      <= $signed(csr_wdata);
            CSR_HYSTERESIS:       hyst_ff       <= csr_wdata[14:0];
            CSR_HOLD_LIMIT:       hold_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample step: decimated store, then wait for a crossing, a timeout or a lost external trigger
   always_comb begin
      wp_in     = wp_ff;
      hw_in     = hw_ff;
      full_in   = full_ff;
      fc_in     = fc_ff;
      sch_in    = sch_ff;
      active_in = active_ff;
      wr_en     = 1'b0;
      restart   = 1'b0;
      fc_a      = fc_ff;
      if (accept && (req_data.op == OP_SAMPLE)) begin
         active_in = req_data.x_active;
         if (!full_ff) begin
            fc_a = (fc_ff < CTR_MAX) ? fc_ff + 1'b1 : fc_ff;
            if (fc_a > {1'b0, decimation_ff}) begin
               fc_a  = '0;
               wr_en = 1'b1;
               if (wp_ff >= hw_ff) begin
                  hw_in = wp_ff + 1'b1;
               end
               wp_in = wp_ff + 1'b1;
               if (wp_in >= DEPTH_C) begin
                  wp_in   = DEPTH_C;
                  full_in = 1'b1;
               end
            end
         end
         fc_in = fc_a;
         if (full_in) begin
            if (external_ff && !req_data.trig_active) begin
               restart = 1'b1;
            end else begin
               if (fc_a == '0) begin
                  sch_in = SCH_UNKNOWN;
               end
               fc_in = (fc_a < CTR_MAX) ? fc_a + 1'b1 : fc_a;
               case (sch_in)
                  SCH_LOW: begin
                     if (gate >= hi_th) begin
                        sch_in  = SCH_HIGH;
                        restart = 1'b1;
                     end
                  end
                  SCH_HIGH: begin
                     if (gate <= lo_th) begin
                        sch_in = SCH_LOW;
                     end
                  end
                  default: begin
                     if (gate >= hi_th) begin
                        sch_in = SCH_HIGH;
                     end else if (gate <= lo_th) begin
                        sch_in = SCH_LOW;
                     end
                  end
               endcase
               if (fc_in >= {1'b0, hold_ff}) begin
                  restart = 1'b1;
               end
            end
            if (restart) begin
               wp_in   = '0;
               full_in = 1'b0;
               fc_in   = '0;
            end
         end
      end
   end

   always_comb begin
      s1_in.is_read         = (req_data.op == OP_READ);
      s1_in.hit             = (32'(req_data.read_address) < 32'(DEPTH))
                              && (32'(req_data.read_address) < 32'(hw_ff));
      s1_in.stored_count    = COUNT_W'(wp_in);
      s1_in.waiting_trigger = full_in;
      s1_in.restarted       = restart;
      s1_in.channel_active  = active_in;
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

      out_in.read_data       = (s1_ff.is_read && s1_ff.hit) ? $signed(rd_data) : '0;
      out_in.stored_count    = s1_ff.stored_count;
      out_in.waiting_trigger = s1_ff.waiting_trigger;
      out_in.restarted       = s1_ff.restarted;
      out_in.channel_active  = s1_ff.channel_active;
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         hw_ff        <= '0;
         full_ff      <= 1'b0;
         fc_ff        <= '0;
         sch_ff       <= SCH_UNKNOWN;
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         hw_ff        <= hw_in;
         full_ff      <= full_in;
         fc_ff        <= fc_in;
         sch_ff       <= sch_in;
         active_ff    <= active_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   tsc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(wp_ff)),
      .wr_data (req_data.x_sample),
      .rd_en   (rd_en),
      .rd_addr (AW'(req_data.read_address)),
      .rd_data (rd_data)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/tsc_checker.sv =====
// port-level checks of the triggered capture engine, bound to the top level
// depends on tsc_pkg and triggered_scope_capture_assert.svh
`include "triggered_scope_capture_assert.svh"

module tsc_checker
   import tsc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

   // stalled result transaction holds
   `TSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   // waiting for a trigger only with a full sweep
   `TSC_ASSERT_NOW(a_wait_full, clock, reset, rsp_valid && rsp_data.waiting_trigger,
      rsp_data.stored_count == DEPTH_C)

   // a re-arm empties the sweep
   `TSC_ASSERT_NOW(a_restart_clear, clock, reset, rsp_valid && rsp_data.restarted,
      rsp_data.stored_count == '0 && !rsp_data.waiting_trigger)

   // count never passes the store depth
   `TSC_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid,
      rsp_data.stored_count <= DEPTH_C)

endmodule

bind triggered_scope_capture tsc_checker u_tsc_checker (.*);

// ===== tb/triggered_scope_capture_checker.sv =====
`timescale 1ns / 1ps
// checker for the triggered capture engine: watches the req, rsp and csr ports,
// predicts every result and compares it field by field; depends on tsc_pkg
module triggered_scope_capture_checker
   import tsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               error_count,
   output int               pending
);

   localparam int STORE_DEPTH = 512;

   logic [15:0] decimation;
   logic        ext_trig;
   int          trig_level;
   int          hyst;
   logic [15:0] hold_limit;

   logic signed [SAMPLE_W-1:0] samples [STORE_DEPTH];
   logic [COUNT_W-1:0]         fill_count;
   logic                       armed_full;
   logic [CTR_W-1:0]           decim_count;
   schmitt_type                gate_state;
   logic                       connected;

   rsp_type scope_results_due [$];

   initial error_count = 0;
   initial pending = 0;

   task automatic flag_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic rsp_type advance_scope(input req_type t);
      rsp_type r;
      logic    restart;
      logic    crossed;
      int      gate;
      r = '0;
      restart = 1'b0;
      crossed = 1'b0;
      if (t.op == OP_READ) begin
         r.read_data = samples[t.read_address];
      end else begin
         connected = t.x_active;
         if (!armed_full) begin
            if (decim_count != CTR_MAX) decim_count++;
            if (decim_count > decimation) begin
               decim_count = '0;
               samples[fill_count[ADDR_W-1:0]] = t.x_sample;
               fill_count++;
               if (fill_count >= STORE_DEPTH) armed_full = 1'b1;
            end
         end
         if (armed_full) begin
            if (ext_trig && !t.trig_active) begin
               restart = 1'b1;
            end else begin
               if (decim_count == 0) gate_state = SCH_UNKNOWN;
               if (decim_count != CTR_MAX) decim_count++;
               gate = ext_trig ? int'(t.trig_sample) : int'(t.x_sample);
               // schmitt: upper threshold is the level, lower is level minus hysteresis
               case (gate_state)
                  SCH_LOW: begin
                     if (gate >= trig_level) begin
                        gate_state = SCH_HIGH;
                        crossed = 1'b1;
                     end
                  end
                  SCH_HIGH: begin
                     if (gate <= trig_level - hyst) gate_state = SCH_LOW;
                  end
                  default: begin
                     if (gate >= trig_level) gate_state = SCH_HIGH;
                     else if (gate <= trig_level - hyst) gate_state = SCH_LOW;
                  end
               endcase
               restart = crossed || (decim_count >= hold_limit);
            end
            if (restart) begin
               fill_count = '0;
               armed_full = 1'b0;
               decim_count = '0;
            end
         end
      end
      r.stored_count = fill_count;
      r.waiting_trigger = armed_full;
      r.restarted = restart;
      r.channel_active = connected;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         decimation = 16'd3;
         ext_trig = 1'b0;
         trig_level = 0;
         hyst = 328;
         hold_limit = 16'd4410;
         for (int i = 0; i < STORE_DEPTH; i++) samples[i] = '0;
         fill_count = '0;
         armed_full = 1'b0;
         decim_count = '0;
         gate_state = SCH_UNKNOWN;
         connected = 1'b0;
         scope_results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DECIMATION:       decimation = csr_wdata;
               CSR_EXTERNAL_TRIGGER: ext_trig = csr_wdata[0];
               CSR_TRIGGER_LEVEL:    trig_level = int'($signed(csr_wdata));
               CSR_HYSTERESIS:       hyst = int'({1'b0, csr_wdata[14:0]});
               CSR_HOLD_LIMIT:       hold_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) scope_results_due.push_back(advance_scope(req_data));
         if (rsp_valid && rsp_ready) begin
            if (scope_results_due.size() == 0) begin
               flag_mismatch("transaction with none due", int'(rsp_data.stored_count), 0);
            end else begin
               want = scope_results_due.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  flag_mismatch("read_data", int'(rsp_data.read_data), int'(want.read_data));
               if (rsp_data.stored_count !== want.stored_count)
                  flag_mismatch("stored_count", int'(rsp_data.stored_count),
                                int'(want.stored_count));
               if (rsp_data.waiting_trigger !== want.waiting_trigger)
                  flag_mismatch("waiting_trigger", int'(rsp_data.waiting_trigger),
                                int'(want.waiting_trigger));
               if (rsp_data.restarted !== want.restarted)
                  flag_mismatch("restarted", int'(rsp_data.restarted), int'(want.restarted));
               if (rsp_data.channel_active !== want.channel_active)
                  flag_mismatch("channel_active", int'(rsp_data.channel_active),
                                int'(want.channel_active));
            end
         end
      end
      pending = scope_results_due.size();
   end

endmodule

// ===== tb/triggered_scope_capture_test.sv =====
`timescale 1ns / 1ps
// top of the capture engine testbench: clock, reset, stimulus, receiver stalls and verdict
// depends on tsc_pkg, triggered_scope_capture and triggered_scope_capture_checker
module triggered_scope_capture_test
   import tsc_pkg::*;
();

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [2:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   int               error_count;
   int               pending;

   bit rsp_hold_wanted = 1'b0;
   int burst_left = 0;
   int gate_level = 0;
   int gate_hyst = 328;
   bit gate_quiet = 1'b0;

   always #2 clock = ~clock;

   triggered_scope_capture uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   triggered_scope_capture_checker capture_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   function automatic req_type compose(input op_type op, input int xs, input bit xa,
                                       input int ts, input bit ta, input int addr);
      req_type t;
      t.op = op;
      t.x_sample = xs[SAMPLE_W-1:0];
      t.x_active = xa;
      t.trig_sample = ts[SAMPLE_W-1:0];
      t.trig_active = ta;
      t.read_address = addr[ADDR_W-1:0];
      return t;
   endfunction

   // quiet gates never reach a high threshold near full scale
   function automatic logic signed [SAMPLE_W-1:0] pick_gate();
      int v;
      if (gate_quiet) v = -int'($urandom_range(0, 32768));
      else if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 65535)) - 32768;
      else v = gate_level - gate_hyst - 100 + int'($urandom_range(0, gate_hyst + 200));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_paced(input req_type t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input csr_index_type idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
   endtask

   task automatic set_config(input int dec, input int ext, input int lvl, input int hyst,
                             input int hold);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_csr(CSR_DECIMATION, dec);
      write_csr(CSR_EXTERNAL_TRIGGER, ext);
      write_csr(CSR_TRIGGER_LEVEL, lvl);
      write_csr(CSR_HYSTERESIS, hyst);
      write_csr(CSR_HOLD_LIMIT, hold);
      @(negedge clock);
      csr_we <= 1'b0;
      burst_left = 0;
   endtask

   task automatic run_phase(input int dec, input int ext, input int lvl, input int hyst,
                            input int hold, input bit quiet, input int drop, input int count,
                            input bit squeeze);
      req_type t;
      set_config(dec, ext, lvl, hyst, hold);
      gate_level = lvl;
      gate_hyst = hyst;
      gate_quiet = quiet;
      for (int k = 0; k < count; k++) begin
         if (squeeze && k == 20) rsp_hold_wanted = 1'b1;
         t.op = ($urandom_range(0, 15) == 0) ? OP_READ : OP_SAMPLE;
         t.x_sample = pick_gate();
         t.x_active = ($urandom_range(0, 7) != 0);
         t.trig_sample = pick_gate();
         t.trig_active = ($urandom_range(0, drop - 1) != 0);
         t.read_address = ADDR_W'($urandom);
         send_paced(t);
      end
   endtask

   initial begin : rsp_side
      int mode;
      int span;
      forever begin
         if (rsp_hold_wanted) begin
            // long hold-off so the pipe fills and req_ready drops
            rsp_hold_wanted = 1'b0;
            repeat (300) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            for (int i = 0; i < span; i++) begin
               @(negedge clock);
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ready <= (i % 4 != 3);
                  default: rsp_ready <= ($urandom_range(0, 1) == 1);
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values, extremes of every field
      send_paced(compose(OP_READ, 0, 1'b0, 0, 1'b0, 0));
      send_paced(compose(OP_READ, -1, 1'b1, -1, 1'b1, 511));
      send_paced(compose(OP_SAMPLE, 32767, 1'b1, -32768, 1'b0, 0));
      send_paced(compose(OP_SAMPLE, -32768, 1'b0, 32767, 1'b1, 511));
      send_paced(compose(OP_SAMPLE, 0, 1'b1, 0, 1'b1, 0));
      send_paced(compose(OP_SAMPLE, -1, 1'b1, -1, 1'b0, 0));
      send_paced(compose(OP_SAMPLE, 1, 1'b0, 1, 1'b1, 0));
      send_paced(compose(OP_SAMPLE, -32767, 1'b1, 16384, 1'b0, 0));
      send_paced(compose(OP_SAMPLE, 16384, 1'b1, -16384, 1'b1, 0));
      send_paced(compose(OP_SAMPLE, -16384, 1'b0, 32767, 1'b0, 0));
      send_paced(compose(OP_SAMPLE, 21845, 1'b1, -21846, 1'b1, 0));
      send_paced(compose(OP_SAMPLE, -21846, 1'b1, 21845, 1'b0, 0));
      send_paced(compose(OP_SAMPLE, 32767, 1'b0, -32768, 1'b1, 0));
      send_paced(compose(OP_SAMPLE, -32768, 1'b1, 32767, 1'b1, 0));
      send_paced(compose(OP_READ, 0, 1'b0, 0, 1'b0, 0));
      send_paced(compose(OP_READ, 0, 1'b0, 0, 1'b0, 1));
      send_paced(compose(OP_READ, 0, 1'b0, 0, 1'b0, 2));
      send_paced(compose(OP_READ, 0, 1'b0, 0, 1'b0, 3));
      send_paced(compose(OP_READ, 32767, 1'b1, 32767, 1'b1, 9'h155));
      send_paced(compose(OP_READ, -32768, 1'b0, -32768, 1'b0, 9'h0aa));
      send_paced(compose(OP_SAMPLE, 100, 1'b1, -100, 1'b1, 0));
      send_paced(compose(OP_SAMPLE, -100, 1'b0, 100, 1'b0, 0));

      // largest decimation: nothing gets stored
      run_phase(65535, 0, 32767, 32767, 65535, 1'b0, 8, 30, 1'b0);
      // fill the store and sit waiting with a gate that never crosses
      run_phase(0, 0, 32767, 32767, 65535, 1'b1, 8, 600, 1'b1);
      // zero hold limit re-arms on the first waiting step
      run_phase(0, 0, 32767, 32767, 0, 1'b1, 8, 30, 1'b0);
      // refill, then schmitt crossings around zero
      run_phase(0, 0, 0, 328, 65535, 1'b0, 8, 520, 1'b0);
      // external gate with the trigger input dropping out now and then
      run_phase(0, 1, -32768, 0, 40, 1'b0, 30, 80, 1'b0);
      run_phase(2, 0, -1000, 1, 1, 1'b0, 8, 60, 1'b0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
